>>> rtl/core/afd_pkg.sv
// Shared types, codes and helpers for the frame deframer.
// Used by afd_parse, afd_obuf and amqp_frame_deframer_top; no dependencies.
package afd_pkg;

  localparam int unsigned HdrLen = 7;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegMaxFrameSize = 3'd0;
  localparam logic [2:0] RegEndMarker    = 3'd1;
  localparam logic [2:0] RegMethodCode   = 3'd2;
  localparam logic [2:0] RegHeaderCode   = 3'd3;
  localparam logic [2:0] RegBodyCode     = 3'd4;
  localparam logic [2:0] RegHeartbeatCode = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [31:0] RstMaxFrameSize  = 32'd0;
  localparam logic [7:0]  RstEndMarker     = 8'd206;
  localparam logic [7:0]  RstMethodCode    = 8'd1;
  localparam logic [7:0]  RstHeaderCode    = 8'd2;
  localparam logic [7:0]  RstBodyCode      = 8'd3;
  localparam logic [7:0]  RstHeartbeatCode = 8'd8;

  // Status codes.
  localparam logic [1:0] StOk          = 2'd0;
  localparam logic [1:0] StTooLarge    = 2'd1;
  localparam logic [1:0] StBadEnd      = 2'd2;
  localparam logic [1:0] StUnknownType = 2'd3;

  // Frame kinds.
  localparam logic [2:0] KindMethod    = 3'd0;
  localparam logic [2:0] KindHeader    = 3'd1;
  localparam logic [2:0] KindBody      = 3'd2;
  localparam logic [2:0] KindHeartbeat = 3'd3;
  localparam logic [2:0] KindUnknown   = 3'd4;

  typedef struct packed {
    logic [31:0] max_frame_size;
    logic [7:0]  end_marker;
    logic [7:0]  method_code;
    logic [7:0]  header_code;
    logic [7:0]  body_code;
    logic [7:0]  heartbeat_code;
  } cfg_t;

  typedef struct packed {
    logic        event_res;
    logic [1:0]  status;
    logic [2:0]  frame_kind;
    logic [15:0] channel_id;
    logic [7:0]  data_byte;
    logic [31:0] byte_offset;
    logic [31:0] frame_size;
    logic        last;
  } res_t;

  // The first matching code in the order method, header, body, heartbeat wins.
  function automatic logic [2:0] kind_of(input logic [7:0] t, input cfg_t cfg);
    logic [2:0] k;
    if (t == cfg.method_code) k = KindMethod;
    else if (t == cfg.header_code) k = KindHeader;
    else if (t == cfg.body_code) k = KindBody;
    else if (t == cfg.heartbeat_code) k = KindHeartbeat;
    else k = KindUnknown;
    return k;
  endfunction

endpackage

>>> rtl/core/amqp_frame_deframer_top.sv
// Frame deframer top level: one byte per transfer in, at most one result out.
// Each result is registered: it goes to the output register, or to the skid stage while that holds an earlier one.
// Throughput: one byte per cycle while in_stall_o is low; the parser state updates in a single pass.
// A two-entry output buffer stalls input only when two results are waiting.
// Reset (async, active low) clears parser state and buffer, restores register defaults.
// Depends on afd_pkg, afd_parse and afd_obuf.
module amqp_frame_deframer_top import afd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        event_res_o,
  output logic [1:0]  status_o,
  output logic [2:0]  frame_kind_o,
  output logic [15:0] channel_id_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] byte_offset_o,
  output logic [31:0] frame_size_o,
  output logic        last_o
);

  cfg_t cfg_q;
  logic accept;
  logic res_valid;
  res_t res, out;
  logic buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_frame_size <= RstMaxFrameSize;
      cfg_q.end_marker     <= RstEndMarker;
      cfg_q.method_code    <= RstMethodCode;
      cfg_q.header_code    <= RstHeaderCode;
      cfg_q.body_code      <= RstBodyCode;
      cfg_q.heartbeat_code <= RstHeartbeatCode;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaxFrameSize:  cfg_q.max_frame_size <= cfg_data_i;
        RegEndMarker:     cfg_q.end_marker     <= cfg_data_i[7:0];
        RegMethodCode:    cfg_q.method_code    <= cfg_data_i[7:0];
        RegHeaderCode:    cfg_q.header_code    <= cfg_data_i[7:0];
        RegBodyCode:      cfg_q.body_code      <= cfg_data_i[7:0];
        RegHeartbeatCode: cfg_q.heartbeat_code <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !in_stall_o;

  afd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .byte_i      (in_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  afd_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign event_res_o   = out.event_res;
  assign status_o      = out.status;
  assign frame_kind_o  = out.frame_kind;
  assign channel_id_o  = out.channel_id;
  assign data_byte_o   = out.data_byte;
  assign byte_offset_o = out.byte_offset;
  assign frame_size_o  = out.frame_size;
  assign last_o        = out.last;

endmodule

>>> rtl/core/afd_parse.sv
// Byte-wise frame parser: header collection, payload counting and end check.
// Depends on afd_pkg for the configuration and result types.
module afd_parse import afd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhPayload = 2'd1;
  localparam logic [1:0] PhEnd     = 2'd2;
  localparam logic [1:0] PhHalt    = 2'd3;

  localparam logic [2:0] HdrLast = 3'(HdrLen - 1);

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] size_q, size_d;
  logic [31:0] pcnt_q, pcnt_d;
  logic [2:0]  kind;

  assign kind = kind_of(type_q, cfg_i);

  always_comb begin
    phase_d = phase_q;
    hcnt_d  = hcnt_q;
    type_d  = type_q;
    chan_d  = chan_q;
    size_d  = size_q;
    pcnt_d  = pcnt_q;

    res_valid_o       = 1'b0;
    res_o.event_res   = 1'b0;
    res_o.status      = StOk;
    res_o.frame_kind  = kind;
    res_o.channel_id  = chan_q;
    res_o.data_byte   = 8'd0;
    res_o.byte_offset = 32'd0;
    res_o.frame_size  = size_q;
    res_o.last        = 1'b0;

    if (accept_i) begin
      case (phase_q)
        PhHeader: begin
          if (hcnt_q == 3'd0) begin
            type_d = byte_i;
          end else if (hcnt_q inside {[3'd1:3'd2]}) begin
            chan_d = {chan_q[7:0], byte_i};
          end else begin
            size_d = {size_q[23:0], byte_i};
          end
          if (hcnt_q == HdrLast) begin
            hcnt_d = 3'd0;
            pcnt_d = 32'd0;
            if (cfg_i.max_frame_size != 32'd0 && size_d > cfg_i.max_frame_size) begin
              // Oversized frame: report once, then ignore the stream until reset.
              phase_d          = PhHalt;
              res_valid_o      = 1'b1;
              res_o.event_res  = 1'b1;
              res_o.status     = StTooLarge;
              res_o.frame_size = size_d;
              res_o.last       = 1'b1;
            end else begin
              phase_d = (size_d == 32'd0) ? PhEnd : PhPayload;
            end
          end else begin
            hcnt_d = hcnt_q + 3'd1;
          end
        end
        PhPayload: begin
          res_valid_o       = 1'b1;
          res_o.data_byte   = byte_i;
          res_o.byte_offset = pcnt_q;
          pcnt_d            = pcnt_q + 32'd1;
          if (pcnt_d >= size_q) begin
            phase_d = PhEnd;
          end
        end
        PhEnd: begin
          res_valid_o     = 1'b1;
          res_o.event_res = 1'b1;
          res_o.last      = 1'b1;
          if (byte_i != cfg_i.end_marker) begin
            res_o.status = StBadEnd;
          end else if (kind == KindUnknown) begin
            res_o.status = StUnknownType;
          end else begin
            res_o.status = StOk;
          end
          phase_d = PhHeader;
          hcnt_d  = 3'd0;
          pcnt_d  = 32'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      hcnt_q  <= 3'd0;
      type_q  <= 8'd0;
      chan_q  <= 16'd0;
      size_q  <= 32'd0;
      pcnt_q  <= 32'd0;
    end else begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      type_q  <= type_d;
      chan_q  <= chan_d;
      size_q  <= size_d;
      pcnt_q  <= pcnt_d;
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHalt |=> phase_q == PhHalt)
    else $error("parser left the halt phase without reset");

  a_hcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= HdrLast)
    else $error("header byte count out of range");

  a_payload_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> pcnt_q < size_q)
    else $error("payload offset reached the frame size while in payload phase");

endmodule

>>> rtl/core/afd_obuf.sv
// Output register with a skid stage, so the parser keeps taking bytes while a
// result waits. Depends on afd_pkg for the result type.
module afd_obuf import afd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_o
);

  logic out_vld_q, skid_vld_q;
  res_t out_q, skid_q;
  logic pop;

  assign pop         = out_vld_q && !out_stall_i;
  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      out_q <= skid_vld_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid stage holds a result while the output register is empty");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_vld_q)
    else $error("result pushed while the skid stage is full");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(out_q))
    else $error("stalled result changed before its transfer");

endmodule

>>> test/amqp_frame_deframer_top_test.sv
// Self-checking testbench for amqp_frame_deframer_top: queued frame bytes are driven in,
// and a byte-level deframer model predicts every payload and frame-done result.
// Depends on afd_pkg and the deframer RTL.
module amqp_frame_deframer_top_test;
  import afd_pkg::*;

  localparam int HoldLen       = 300;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 4;
  localparam int SubPhaseBytes = 165;
  localparam int MaxReports    = 10;

  localparam logic EvPayload = 1'b0;
  localparam logic EvDone    = 1'b1;

  typedef enum logic [1:0] {PhHeader, PhPayload, PhEnd, PhHalt} parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic        tx_valid = 1'b0;
  logic [7:0]  tx_byte = '0;
  logic        rx_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        ev_o, last_o;
  logic [1:0]  status_o;
  logic [2:0]  kind_o;
  logic [15:0] chan_o;
  logic [7:0]  data_o;
  logic [31:0] offset_o, size_o;
  logic        in_xfer, out_xfer;

  amqp_frame_deframer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (tx_valid),
    .in_stall_o    (in_stall),
    .in_byte_i     (tx_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (rx_stall),
    .event_res_o   (ev_o),
    .status_o      (status_o),
    .frame_kind_o  (kind_o),
    .channel_id_o  (chan_o),
    .data_byte_o   (data_o),
    .byte_offset_o (offset_o),
    .frame_size_o  (size_o),
    .last_o        (last_o)
  );

  assign in_xfer  = tx_valid && !in_stall;
  assign out_xfer = out_valid && !rx_stall;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus and scoreboard state.
  logic [7:0]   tx_bytes[$];
  res_t         pending_results[$];
  cfg_t         cfg_shadow;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  logic         hold_go = 1'b0;
  int           hold_cycles = 0;
  int           bytes_queued = 0;
  int           settings_applied = 0;
  int           mismatch_count = 0;
  int           results_checked = 0;
  int           payload_seen = 0;
  int           done_seen = 0;

  // Deframer model state.
  parse_phase_e pr_phase;
  logic [2:0]   pr_hdr_cnt;
  logic [7:0]   pr_type;
  logic [15:0]  pr_chan;
  logic [31:0]  pr_size;
  logic [31:0]  pr_count;

  // Checking later codes first and overwriting gives the first match priority.
  function automatic logic [2:0] kind_for(input logic [7:0] t);
    logic [2:0] k;
    k = KindUnknown;
    if (t == cfg_shadow.heartbeat_code) k = KindHeartbeat;
    if (t == cfg_shadow.body_code) k = KindBody;
    if (t == cfg_shadow.header_code) k = KindHeader;
    if (t == cfg_shadow.method_code) k = KindMethod;
    return k;
  endfunction

  function automatic res_t make_res(input logic ev, input logic [1:0] st,
                                    input logic [7:0] d, input logic [31:0] off);
    res_t r;
    r.event_res   = ev;
    r.status      = st;
    r.frame_kind  = kind_for(pr_type);
    r.channel_id  = pr_chan;
    r.data_byte   = d;
    r.byte_offset = off;
    r.frame_size  = pr_size;
    r.last        = ev;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    logic [1:0] st;
    case (pr_phase)
      PhHeader: begin
        if (pr_hdr_cnt == 3'd0) pr_type = b;
        else if (pr_hdr_cnt <= 3'd2) pr_chan = {pr_chan[7:0], b};
        else pr_size = {pr_size[23:0], b};
        if (pr_hdr_cnt == 3'(HdrLen - 1)) begin
          pr_hdr_cnt = '0;
          pr_count = '0;
          if (cfg_shadow.max_frame_size != 0 && pr_size > cfg_shadow.max_frame_size) begin
            pr_phase = PhHalt;
            pending_results = {pending_results, make_res(EvDone, StTooLarge, 8'h00, 32'd0)};
          end else begin
            pr_phase = (pr_size == 0) ? PhEnd : PhPayload;
          end
        end else begin
          pr_hdr_cnt = pr_hdr_cnt + 3'd1;
        end
      end
      PhPayload: begin
        pending_results = {pending_results, make_res(EvPayload, StOk, b, pr_count)};
        pr_count = pr_count + 32'd1;
        if (pr_count >= pr_size) pr_phase = PhEnd;
      end
      PhEnd: begin
        // A bad end marker takes precedence over an unknown type.
        if (b != cfg_shadow.end_marker) st = StBadEnd;
        else if (kind_for(pr_type) == KindUnknown) st = StUnknownType;
        else st = StOk;
        pending_results = {pending_results, make_res(EvDone, st, 8'h00, 32'd0)};
        pr_phase = PhHeader;
        pr_hdr_cnt = '0;
        pr_count = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports)
        $display("ERROR: unexpected result ev=%0d st=%0d kind=%0d ch=%h data=%h off=%0d",
                 got.event_res, got.status, got.frame_kind, got.channel_id,
                 got.data_byte, got.byte_offset);
    end else begin
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("ERROR: exp ev=%0d st=%0d kind=%0d ch=%h data=%h off=%0d size=%0d last=%0d",
                   want.event_res, want.status, want.frame_kind, want.channel_id,
                   want.data_byte, want.byte_offset, want.frame_size, want.last);
          $display("       got ev=%0d st=%0d kind=%0d ch=%h data=%h off=%0d size=%0d last=%0d",
                   got.event_res, got.status, got.frame_kind, got.channel_id,
                   got.data_byte, got.byte_offset, got.frame_size, got.last);
        end
      end
    end
    results_checked++;
    if (got.event_res == EvDone) done_seen++;
    else payload_seen++;
  endtask

  // Driver: a new byte is offered only once the previous transfer has happened.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_valid <= 1'b0;
      tx_byte  <= '0;
    end else if (!tx_valid || !in_stall) begin
      if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        tx_valid <= 1'b1;
        tx_byte  <= tx_bytes.pop_front();
      end else begin
        tx_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_stall    <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_go && hold_cycles < HoldLen) begin
      rx_stall    <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      rx_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Monitor: results are checked before the byte of the same edge is modeled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_phase   <= PhHeader;
      pr_hdr_cnt <= '0;
      pr_type    <= '0;
      pr_chan    <= '0;
      pr_size    <= '0;
      pr_count   <= '0;
    end else begin
      if (out_xfer)
        check_result('{ev_o, status_o, kind_o, chan_o, data_o, offset_o, size_o, last_o});
      if (in_xfer) deframe_byte(tx_byte);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if (in_xfer || out_xfer) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("ERROR: no transfer for %0d cycles", WatchdogLimit);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    tx_bytes = {tx_bytes, b};
    bytes_queued++;
  endtask

  task automatic queue_header(input logic [7:0] t, input logic [15:0] ch,
                              input logic [31:0] sz);
    push_byte(t);
    push_byte(ch[15:8]);
    push_byte(ch[7:0]);
    push_byte(sz[31:24]);
    push_byte(sz[23:16]);
    push_byte(sz[15:8]);
    push_byte(sz[7:0]);
  endtask

  // A negative fill gives random payload bytes.
  task automatic queue_frame(input logic [7:0] t, input logic [15:0] ch,
                             input logic [31:0] sz, input int fill, input logic [7:0] eb);
    queue_header(t, ch, sz);
    for (int i = 0; i < sz; i++) push_byte((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
    push_byte(eb);
  endtask

  task automatic queue_random_frame();
    logic [7:0]  t, eb;
    logic [15:0] ch;
    logic [31:0] sz;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 20) t = cfg_shadow.method_code;
    else if (pick < 40) t = cfg_shadow.header_code;
    else if (pick < 60) t = cfg_shadow.body_code;
    else if (pick < 72) t = cfg_shadow.heartbeat_code;
    else t = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 5) ch = 16'h0000;
    else if (pick < 10) ch = 16'hFFFF;
    else ch = 16'($urandom_range(65535));
    sz = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(64, 13);
    if (cfg_shadow.max_frame_size != 0 && sz > cfg_shadow.max_frame_size)
      sz = $urandom_range(cfg_shadow.max_frame_size);
    eb = ($urandom_range(99) < 85) ? cfg_shadow.end_marker : 8'($urandom_range(255));
    queue_frame(t, ch, sz, -1, eb);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      RegMaxFrameSize:  cfg_shadow.max_frame_size = val;
      RegEndMarker:     cfg_shadow.end_marker = val[7:0];
      RegMethodCode:    cfg_shadow.method_code = val[7:0];
      RegHeaderCode:    cfg_shadow.header_code = val[7:0];
      RegBodyCode:      cfg_shadow.body_code = val[7:0];
      RegHeartbeatCode: cfg_shadow.heartbeat_code = val[7:0];
      default: ;
    endcase
  endtask

  // Writes every register, then the two unused indexes, which must be ignored.
  task automatic program_cfg(input logic [31:0] max_sz, input logic [7:0] eb,
                             input logic [7:0] m, input logic [7:0] h,
                             input logic [7:0] bd, input logic [7:0] hb);
    write_reg(RegMaxFrameSize, max_sz);
    write_reg(RegEndMarker, {24'd0, eb});
    write_reg(RegMethodCode, {24'd0, m});
    write_reg(RegHeaderCode, {24'd0, h});
    write_reg(RegBodyCode, {24'd0, bd});
    write_reg(RegHeartbeatCode, {24'd0, hb});
    write_reg(3'(RegHeartbeatCode + 1), $urandom);
    write_reg(3'(RegHeartbeatCode + 2), $urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic wait_idle();
    while (tx_bytes.size() != 0 || tx_valid || pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_setting(input int n);
    case (n)
      0: program_cfg(32'd0, RstEndMarker, RstMethodCode, RstHeaderCode, RstBodyCode,
                     RstHeartbeatCode);
      1: program_cfg(32'hFFFF_FFFF, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F);
      2: program_cfg(32'd20, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
      3: begin
        // Body and heartbeat share a code, so heartbeat frames never appear.
        logic [7:0] shared;
        shared = 8'($urandom);
        program_cfg($urandom_range(40, 1), 8'($urandom), 8'($urandom), 8'($urandom),
                    shared, shared);
      end
      4: program_cfg(32'd0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
      default: program_cfg($urandom_range(64, 12), 8'($urandom), RstMethodCode,
                           RstHeaderCode, RstBodyCode, RstHeartbeatCode);
    endcase
  endtask

  task automatic random_segment(input int setting);
    int start;
    wait_idle();
    apply_setting(setting);
    start = bytes_queued;
    while (bytes_queued - start < SubPhaseBytes) queue_random_frame();
  endtask

  initial begin
    cfg_shadow = '{RstMaxFrameSize, RstEndMarker, RstMethodCode, RstHeaderCode,
                   RstBodyCode, RstHeartbeatCode};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset configuration.
    tx_idle_pct <= 25;
    rx_idle_pct <= 25;
    queue_frame(RstMethodCode, 16'h0000, 32'd1, 8'h00, RstEndMarker);
    queue_frame(RstHeaderCode, 16'hFFFF, 32'd2, 8'hFF, RstEndMarker);
    queue_frame(RstBodyCode, 16'h1234, 32'd1, 8'h5A, RstEndMarker);
    queue_frame(RstHeartbeatCode, 16'h0001, 32'd0, 0, RstEndMarker);
    queue_frame(8'h77, 16'h00FF, 32'd0, 0, RstEndMarker);
    queue_frame(8'h77, 16'hFF00, 32'd0, 0, 8'h00);
    queue_frame(RstMethodCode, 16'h8001, 32'd1, 8'hA5, 8'h01);

    // Duplicate method and header codes, and a frame exactly at the size limit.
    wait_idle();
    program_cfg(32'd8, 8'hFF, 8'h10, 8'h10, 8'h00, 8'hFF);
    queue_frame(8'h10, 16'h4242, 32'd8, -1, 8'hFF);
    queue_frame(8'h00, 16'h0000, 32'd0, 0, 8'hFF);
    queue_frame(8'hFF, 16'hFFFF, 32'd0, 0, 8'h00);

    tx_idle_pct <= 11;
    rx_idle_pct <= 86;
    random_segment(0);
    random_segment(1);

    tx_idle_pct <= 86;
    rx_idle_pct <= 11;
    random_segment(2);
    random_segment(3);

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    random_segment(4);
    hold_go <= 1'b1;
    random_segment(5);

    // An oversized header halts the block; the frame after it must be ignored.
    wait_idle();
    program_cfg(32'd1, cfg_shadow.end_marker, cfg_shadow.method_code,
                cfg_shadow.header_code, cfg_shadow.body_code, cfg_shadow.heartbeat_code);
    queue_header(cfg_shadow.method_code, 16'hABCD, 32'hFFFF_FFFF);
    queue_frame(cfg_shadow.method_code, 16'h0001, 32'd1, -1, cfg_shadow.end_marker);

    while (tx_bytes.size() != 0 || tx_valid || pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes, %0d settings, %0d results (%0d payload, %0d done).",
             bytes_queued, settings_applied, results_checked, payload_seen, done_seen);
    $display("Covered every frame kind, bad ends, unknown types, a long hold-off and the halt.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results still pending", mismatch_count,
               pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
